### rtl/alps_pkg.sv
// Package for the adaptive low-pass pose smoother.
// Holds the shared types, fixed-point constants and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package alps_pkg;

	// Kind of work that the front assigns to an item.
	typedef enum logic [1:0] {
		K_PASS = 2'd0,
		K_SEED = 2'd1,
		K_FILT = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_REST = 2'd0;
	localparam logic [1:0] CFG_GAIN = 2'd1;
	localparam logic [1:0] CFG_GAP  = 2'd2;

	// Fixed-point constants.
	localparam logic [18:0] TWO_PI_Q16       = 19'd411775;
	localparam logic [19:0] US_PER_S         = 20'd1000000;
	localparam logic [47:0] WEIGHT_DEN       = 48'd65536000000;
	localparam logic [60:0] PRODUCT_CAP      = 61'h200000000000;
	localparam logic [5:0]  SPEED_DIV_STEPS  = 6'd52;
	localparam logic [5:0]  WEIGHT_DIV_STEPS = 6'd16;

	typedef struct packed {
		logic [23:0] rest_cutoff;
		logic [23:0] speed_gain;
		logic [19:0] gap_limit_us;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [5:0]         point;
		logic               axis;
		logic signed [31:0] raw;
		logic [19:0]        dt;
		logic [6:0]         entry;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [47:0] rem0;
		logic [51:0] low;
		logic [47:0] divisor;
		logic [5:0]  count;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [51:0] quot;
	} div_rsp_t;

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/alps_fifo.sv
// Short item queue between the front and the back of the pose smoother.
// Depends on alps_pkg for the item type.
`timescale 1ns / 1ps

module alps_fifo import alps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  not_empty,
	output logic  full
);

	item_t      slot_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;

	assign head      = slot_q[rd_q];
	assign not_empty = (count_q != 3'd0);
	assign full      = (count_q == 3'd4);

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			count_q <= count_q + {2'b0, push} - {2'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("pop from empty queue");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !full) |=> (count_q == $past(count_q) + 3'd1))
		else $error("fill count did not advance");
`endif

endmodule

### rtl/alps_front.sv
// Front of the pose smoother: accepts coordinates and classifies them.
// Keeps the per-entry started flags; depends on alps_pkg.
`timescale 1ns / 1ps

module alps_front import alps_pkg::*; #(
	parameter int POINT_COUNT = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         point_index,
	input  logic               axis_select,
	input  logic signed [31:0] raw_value,
	input  logic [19:0]        interval_us,
	input  logic               queue_full,
	output logic               push,
	output item_t              push_item
);

	localparam int ENTRIES = 2 * POINT_COUNT;
	localparam int EW      = $clog2(ENTRIES);

	logic [ENTRIES-1:0] started_q;
	logic [6:0]         entry_full;
	logic [EW-1:0]      entry;
	logic               in_range;
	kind_t              kind;

	assign in_stall   = queue_full;
	assign push       = in_valid && !queue_full;
	assign entry_full = {point_index, axis_select};
	assign entry      = entry_full[EW-1:0];
	assign in_range   = ({1'b0, point_index} < 7'(POINT_COUNT));

	// Classify the request against the flags left by earlier requests.
	always_comb begin
		if (cfg.rest_cutoff == 24'd0 || !in_range || interval_us == 20'd0) begin
			kind = K_PASS;
		end else if (interval_us > cfg.gap_limit_us || !started_q[entry]) begin
			kind = K_SEED;
		end else begin
			kind = K_FILT;
		end
	end

	always_comb begin
		push_item.kind  = kind;
		push_item.point = point_index;
		push_item.axis  = axis_select;
		push_item.raw   = raw_value;
		push_item.dt    = interval_us;
		push_item.entry = entry_full;
	end

	// Started flags: a zero interval clears, a seed sets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
		end else if (push && cfg.rest_cutoff != 24'd0 && in_range) begin
			if (interval_us == 20'd0) begin
				started_q[entry] <= 1'b0;
			end else if (kind == K_SEED) begin
				started_q[entry] <= 1'b1;
			end
		end
	end

endmodule

### rtl/alps_div.sv
// Iterative restoring divider for the pose smoother, one quotient bit a cycle.
// Shared by the speed and weight divisions; depends on alps_pkg.
`timescale 1ns / 1ps

module alps_div import alps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [47:0] rem_q;
	logic [51:0] low_q;
	logic [51:0] quot_q;
	logic [47:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] shifted;
	logic        fits;

	assign shifted  = {rem_q, low_q[51]};
	assign fits     = (shifted >= {1'b0, div_q});
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem0;
			low_q  <= req.low;
			quot_q <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? 48'(shifted - {1'b0, div_q}) : shifted[47:0];
			low_q  <= {low_q[50:0], 1'b0};
			quot_q <= {quot_q[50:0], fits};
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.count;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

### rtl/alps_back.sv
// Back of the pose smoother: the filter sequencer, state memories and output register.
// Uses alps_div for the divisions; depends on alps_pkg.
`timescale 1ns / 1ps

module alps_back import alps_pkg::*; #(
	parameter int POINT_COUNT = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  item_t              head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         out_point,
	output logic               out_axis,
	output logic signed [31:0] smoothed_value
);

	localparam int ENTRIES = 2 * POINT_COUNT;
	localparam int EW      = $clog2(ENTRIES);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_RD    = 14'b00000000000010,
		ST_SDS   = 14'b00000000000100,
		ST_DIVS  = 14'b00000000001000,
		ST_W1S   = 14'b00000000010000,
		ST_DIVW1 = 14'b00000000100000,
		ST_SPD   = 14'b00000001000000,
		ST_CUT   = 14'b00000010000000,
		ST_PRD   = 14'b00000100000000,
		ST_NMUL  = 14'b00001000000000,
		ST_W2S   = 14'b00010000000000,
		ST_DIVW2 = 14'b00100000000000,
		ST_VAL   = 14'b01000000000000,
		ST_FIN   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] vmem_q [ENTRIES];
	logic signed [31:0] smem_q [ENTRIES];
	logic signed [31:0] vrd_q;
	logic signed [31:0] srd_q;

	logic [5:0]         point_q;
	logic               axis_q;
	logic [EW-1:0]      entry_q;
	logic signed [31:0] raw_q;
	logic [19:0]        dt_q;
	logic               neg_q;
	logic [51:0]        num_q;
	logic [47:0]        n_q;
	logic signed [31:0] spd_q;
	logic [15:0]        w_q;
	logic signed [31:0] fs_q;
	logic [40:0]        cut_q;
	logic [45:0]        p_q;
	logic signed [31:0] fv_q;

	logic               out_free;
	logic               mem_we;
	logic [EW-1:0]      mem_wa;
	logic signed [31:0] mem_wv;
	logic signed [31:0] mem_ws;
	logic [6:0]         head_entry;

	div_req_t           dreq;
	div_rsp_t           drsp;

	logic signed [32:0] vdiff;
	logic [32:0]        vdiff_abs;
	logic [52:0]        num_full;
	logic [38:0]        n1;
	logic signed [31:0] spd_sat;
	logic signed [32:0] sdiff;
	logic signed [49:0] sprod;
	logic signed [63:0] fs_sum;
	logic [32:0]        fs_neg;
	logic [31:0]        fs_mag;
	logic [55:0]        gprod;
	logic [60:0]        pfull;
	logic [64:0]        nfull;
	logic signed [32:0] fdiff;
	logic signed [49:0] fprod;
	logic signed [63:0] fv_sum;

	assign out_free   = !out_valid || !out_stall;
	assign head_entry = head.entry;

	alps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Speed numerator from the fresh memory read.
	always_comb begin
		vdiff     = $signed({raw_q[31], raw_q}) - $signed({vrd_q[31], vrd_q});
		vdiff_abs = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
		num_full  = vdiff_abs * US_PER_S;
		n1        = dt_q * TWO_PI_Q16;
	end

	// Signed, saturated speed from the unsigned quotient.
	always_comb begin
		if (neg_q) begin
			if ((|drsp.quot[51:32]) || (drsp.quot[31] && (|drsp.quot[30:0]))) begin
				spd_sat = 32'sh80000000;
			end else begin
				spd_sat = 32'(-$signed({1'b0, drsp.quot[31:0]}));
			end
		end else if (|drsp.quot[51:31]) begin
			spd_sat = 32'sh7fffffff;
		end else begin
			spd_sat = $signed(drsp.quot[31:0]);
		end
	end

	// Speed low-pass, cutoff and weight product terms.
	always_comb begin
		sdiff  = $signed({spd_q[31], spd_q}) - $signed({srd_q[31], srd_q});
		sprod  = $signed({1'b0, w_q}) * sdiff;
		fs_sum = 64'(srd_q) + 64'(sprod >>> 16);
		fs_neg = 33'(-$signed({fs_q[31], fs_q}));
		fs_mag = fs_q[31] ? fs_neg[31:0] : fs_q;
		gprod  = cfg.speed_gain * fs_mag;
		pfull  = cut_q * dt_q;
		nfull  = p_q * TWO_PI_Q16;
		fdiff  = $signed({raw_q[31], raw_q}) - $signed({vrd_q[31], vrd_q});
		fprod  = $signed({1'b0, w_q}) * fdiff;
		fv_sum = 64'(vrd_q) + 64'(fprod >>> 16);
	end

	// Divider requests for the speed and the two weights.
	always_comb begin
		dreq = '0;
		case (state_q)
			ST_SDS: begin
				dreq.start   = 1'b1;
				dreq.low     = num_q;
				dreq.divisor = {28'b0, dt_q};
				dreq.count   = SPEED_DIV_STEPS;
			end
			ST_W1S, ST_W2S: begin
				dreq.start   = 1'b1;
				dreq.rem0    = n_q;
				dreq.divisor = n_q + WEIGHT_DEN;
				dreq.count   = WEIGHT_DIV_STEPS;
			end
			default: begin
				dreq = '0;
			end
		endcase
	end

	// Queue pops and state memory writes.
	always_comb begin
		pop    = 1'b0;
		mem_we = 1'b0;
		mem_wa = head_entry[EW-1:0];
		mem_wv = head.raw;
		mem_ws = 32'sd0;
		if (state_q == ST_IDLE && head_valid) begin
			if (head.kind == K_FILT) begin
				pop = 1'b1;
			end else if (out_free) begin
				pop    = 1'b1;
				mem_we = (head.kind == K_SEED);
			end
		end else if (state_q == ST_FIN && out_free) begin
			mem_we = 1'b1;
			mem_wa = entry_q;
			mem_wv = fv_q;
			mem_ws = fs_q;
		end
	end

	// State memories with registered reads; the read data is held while an item is filtered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem_q[mem_wa] <= mem_wv;
			smem_q[mem_wa] <= mem_ws;
		end
		if (state_q == ST_IDLE) begin
			vrd_q <= vmem_q[head_entry[EW-1:0]];
			srd_q <= smem_q[head_entry[EW-1:0]];
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				point_q <= head.point;
				axis_q  <= head.axis;
				entry_q <= head_entry[EW-1:0];
				raw_q   <= head.raw;
				dt_q    <= head.dt;
			end
			ST_RD: begin
				neg_q <= vdiff[32];
				num_q <= num_full[51:0];
				n_q   <= {9'b0, n1};
			end
			ST_DIVS: begin
				if (drsp.done) begin
					spd_q <= spd_sat;
				end
			end
			ST_DIVW1, ST_DIVW2: begin
				if (drsp.done) begin
					w_q <= drsp.quot[15:0];
				end
			end
			ST_SPD: begin
				fs_q <= sat32(fs_sum);
			end
			ST_CUT: begin
				cut_q <= 41'(cfg.rest_cutoff) + 41'(gprod[55:16]);
			end
			ST_PRD: begin
				p_q <= (pfull > PRODUCT_CAP) ? PRODUCT_CAP[45:0] : pfull[45:0];
			end
			ST_NMUL: begin
				n_q <= nfull[63:16];
			end
			ST_VAL: begin
				fv_q <= sat32(fv_sum);
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head_valid && head.kind == K_FILT) begin
						state_q <= ST_RD;
					end
				end
				ST_RD:    state_q <= ST_SDS;
				ST_SDS:   state_q <= ST_DIVS;
				ST_DIVS:  state_q <= drsp.done ? ST_W1S : ST_DIVS;
				ST_W1S:   state_q <= ST_DIVW1;
				ST_DIVW1: state_q <= drsp.done ? ST_SPD : ST_DIVW1;
				ST_SPD:   state_q <= ST_CUT;
				ST_CUT:   state_q <= ST_PRD;
				ST_PRD:   state_q <= ST_NMUL;
				ST_NMUL:  state_q <= ST_W2S;
				ST_W2S:   state_q <= ST_DIVW2;
				ST_DIVW2: state_q <= drsp.done ? ST_VAL : ST_DIVW2;
				ST_VAL:   state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: filled from a finished item or a pass-through or seeding request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= (state_q == ST_FIN) || (pop && head.kind != K_FILT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_FIN) begin
				out_point      <= point_q;
				out_axis       <= axis_q;
				smoothed_value <= fv_q;
			end else begin
				out_point      <= head.point;
				out_axis       <= head.axis;
				smoothed_value <= head.raw;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_DIVS || state_q == ST_DIVW1 || state_q == ST_DIVW2))
		else $error("divider finished outside a wait state");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && head_valid))
		else $error("queue popped while busy");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid && smoothed_value == $past(fv_q)))
		else $error("filtered result not delivered");
`endif

endmodule

### rtl/adaptive_lowpass_pose_smoother.sv
// Top level of the adaptive low-pass pose smoother: configuration registers,
// front, queue and back. Depends on alps_pkg, alps_front, alps_fifo, alps_back.
`timescale 1ns / 1ps

// Speed-adaptive (One Euro style) low-pass for landmark coordinates in Q16.16.
// Each request carries one point, axis, raw value and frame interval and yields
// exactly one result, in order. A four-entry queue lets requests be accepted
// while the back works. Pass-through and seeding requests (bypass, point out of
// range, zero interval, first sample, gap restart) leave the back straight from idle
// once the output register is free. A filtered request runs through the sequencer
// and the shared one-bit-a-cycle divider: 52 steps for the speed and 16 for each of
// the two weights. Configuration writes are always ready and take effect at once.
module adaptive_lowpass_pose_smoother import alps_pkg::*; #(
	parameter int POINT_COUNT = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         point_index,
	input  logic               axis_select,
	input  logic signed [31:0] raw_value,
	input  logic [19:0]        interval_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         out_point,
	output logic               out_axis,
	output logic signed [31:0] smoothed_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	cfg_t  cfg_q;
	logic  push;
	item_t push_item;
	logic  pop;
	item_t head;
	logic  not_empty;
	logic  full;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_cutoff  <= 24'd65536;
			cfg_q.speed_gain   <= 24'd3277;
			cfg_q.gap_limit_us <= 20'd500000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REST: cfg_q.rest_cutoff  <= cfg_data;
				CFG_GAIN: cfg_q.speed_gain   <= cfg_data;
				CFG_GAP:  cfg_q.gap_limit_us <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

	alps_front #(.POINT_COUNT(POINT_COUNT)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.point_index (point_index),
		.axis_select (axis_select),
		.raw_value   (raw_value),
		.interval_us (interval_us),
		.queue_full  (full),
		.push        (push),
		.push_item   (push_item)
	);

	alps_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	alps_back #(.POINT_COUNT(POINT_COUNT)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (head),
		.head_valid     (not_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_point      (out_point),
		.out_axis       (out_axis),
		.smoothed_value (smoothed_value)
	);

endmodule
